/* rtl/core/clr_pkg.sv */
`timescale 1ns / 1ps

package clr_pkg;

    localparam int MAX_DIM_DEF = 64;
    localparam int IN_W        = 16;
    localparam int COORD_W     = 6;
    localparam int DIM_W       = 7;
    localparam int COLOR_W     = 32;
    localparam int ERR_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int QDEPTH      = 2;

    localparam logic [DIM_W-1:0]   DIM_RESET   = 7'd64;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_COLOR  = 2'd2
    } cfg_reg_t;

    // Clamped endpoints plus the Bresenham setup for one line.
    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic [COORD_W-1:0] dx;
        logic [COORD_W-1:0] ady;
        logic               sx_neg;
        logic               sy_neg;
    } line_setup_t;

endpackage

/* rtl/core/clr_front.sv */
`timescale 1ns / 1ps

module clr_front #(
    parameter int MAX_DIM = clr_pkg::MAX_DIM_DEF
) (
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [clr_pkg::IN_W-1:0]  start_x,
    input  logic signed [clr_pkg::IN_W-1:0]  start_y,
    input  logic signed [clr_pkg::IN_W-1:0]  end_x,
    input  logic signed [clr_pkg::IN_W-1:0]  end_y,
    input  logic [clr_pkg::DIM_W-1:0]        canvas_width,
    input  logic [clr_pkg::DIM_W-1:0]        canvas_height,
    input  logic                             q_full,
    output logic                             q_push,
    output clr_pkg::line_setup_t             q_data
);

    localparam logic [clr_pkg::DIM_W-1:0] MAXD = clr_pkg::DIM_W'(MAX_DIM);

    logic [clr_pkg::COORD_W-1:0] hi_x;
    logic [clr_pkg::COORD_W-1:0] hi_y;
    logic [clr_pkg::COORD_W-1:0] cx0, cy0, cx1, cy1;

    // Largest legal coordinate for a canvas dimension; zero acts as one.
    function automatic logic [clr_pkg::COORD_W-1:0] top_coord(
        input logic [clr_pkg::DIM_W-1:0] d
    );
        logic [clr_pkg::DIM_W-1:0] t;
        begin
            if (d == '0)
            begin
                t = '0;
            end
            else if (d > MAXD)
            begin
                t = MAXD - clr_pkg::DIM_W'(1);
            end
            else
            begin
                t = d - clr_pkg::DIM_W'(1);
            end
            top_coord = t[clr_pkg::COORD_W-1:0];
        end
    endfunction

    function automatic logic [clr_pkg::COORD_W-1:0] clamp(
        input logic signed [clr_pkg::IN_W-1:0] v,
        input logic [clr_pkg::COORD_W-1:0]     hi
    );
        logic [clr_pkg::COORD_W-1:0] r;
        begin
            if (v[clr_pkg::IN_W-1])
            begin
                r = '0;
            end
            else if (v > $signed({{(clr_pkg::IN_W-clr_pkg::COORD_W){1'b0}}, hi}))
            begin
                r = hi;
            end
            else
            begin
                r = v[clr_pkg::COORD_W-1:0];
            end
            clamp = r;
        end
    endfunction

    assign hi_x = top_coord(canvas_width);
    assign hi_y = top_coord(canvas_height);

    assign cx0 = clamp(start_x, hi_x);
    assign cy0 = clamp(start_y, hi_y);
    assign cx1 = clamp(end_x, hi_x);
    assign cy1 = clamp(end_y, hi_y);

    always_comb
    begin
        q_data.x0     = cx0;
        q_data.y0     = cy0;
        q_data.x1     = cx1;
        q_data.y1     = cy1;
        q_data.sx_neg = !(cx1 > cx0);
        q_data.sy_neg = !(cy1 > cy0);
        q_data.dx     = (cx1 > cx0) ? (cx1 - cx0) : (cx0 - cx1);
        q_data.ady    = (cy1 > cy0) ? (cy1 - cy0) : (cy0 - cy1);
    end

    // Hold the request while the queue has no room.
    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

endmodule

/* rtl/core/clr_fifo.sv */
`timescale 1ns / 1ps

module clr_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  clr_pkg::line_setup_t push_data,
    input  logic                 pop,
    output clr_pkg::line_setup_t pop_data,
    output logic                 full,
    output logic                 empty
);

    localparam int PTR_W = (clr_pkg::QDEPTH > 1) ? $clog2(clr_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(clr_pkg::QDEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(clr_pkg::QDEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(clr_pkg::QDEPTH);

    clr_pkg::line_setup_t mem_reg [clr_pkg::QDEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = (cnt_reg == DEPTH_CNT);
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_CNT)
        else $error("queue count beyond depth");

endmodule

/* rtl/core/clr_back.sv */
`timescale 1ns / 1ps

module clr_back #(
    parameter int MAX_DIM = clr_pkg::MAX_DIM_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_empty,
    input  clr_pkg::line_setup_t               q_data,
    output logic                               q_pop,
    input  logic [clr_pkg::COLOR_W-1:0]        draw_color,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [clr_pkg::COORD_W-1:0]        pixel_x,
    output logic [clr_pkg::COORD_W-1:0]        pixel_y,
    output logic [clr_pkg::COLOR_W-1:0]        pixel_color,
    output logic                               last_pixel
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(MAX_DIM - 1);
    localparam int EXT_W = clr_pkg::ERR_W - clr_pkg::COORD_W;
    localparam int CW    = clr_pkg::COORD_W;
    localparam int EW    = clr_pkg::ERR_W;

    logic                busy_reg, busy_next;
    logic [CW-1:0]       x_reg, x_next;
    logic [CW-1:0]       y_reg, y_next;
    logic [CW-1:0]       x1_reg, x1_next;
    logic [CW-1:0]       y1_reg, y1_next;
    logic [CW-1:0]       dx_reg, dx_next;
    logic [CW-1:0]       ady_reg, ady_next;
    logic                sx_neg_reg, sx_neg_next;
    logic                sy_neg_reg, sy_neg_next;
    logic signed [EW-1:0] err_reg, err_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic                out_valid_reg, out_valid_next;
    logic [CW-1:0]       pixel_x_reg, pixel_x_next;
    logic [CW-1:0]       pixel_y_reg, pixel_y_next;
    logic [clr_pkg::COLOR_W-1:0] pixel_color_reg, pixel_color_next;
    logic                last_pixel_reg, last_pixel_next;

    logic signed [EW-1:0] dx_s, dy_s;
    logic signed [EW:0]   e2, dx_w, dy_w;
    logic                 at_end, step_x, stop_x, step_y, stop_y, done, emit;

    assign dx_s = $signed({{EXT_W{1'b0}}, dx_reg});
    assign dy_s = -$signed({{EXT_W{1'b0}}, ady_reg});
    assign e2   = $signed({err_reg, 1'b0});
    assign dx_w = $signed({dx_s[EW-1], dx_s});
    assign dy_w = $signed({dy_s[EW-1], dy_s});

    // One Bresenham decision on the current pixel.
    assign at_end = (x_reg == x1_reg) && (y_reg == y1_reg);
    assign step_x = (e2 >= dy_w);
    assign stop_x = step_x && (x_reg == x1_reg);
    assign step_y = !stop_x && (e2 <= dx_w);
    assign stop_y = step_y && (y_reg == y1_reg);
    assign done   = at_end || stop_x || stop_y || (cnt_reg == CNT_CAP);

    assign emit  = busy_reg && (!out_valid_reg || !out_stall);
    assign q_pop = !busy_reg && !q_empty;

    always_comb
    begin
        busy_next        = busy_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        x1_next          = x1_reg;
        y1_next          = y1_reg;
        dx_next          = dx_reg;
        ady_next         = ady_reg;
        sx_neg_next      = sx_neg_reg;
        sy_neg_next      = sy_neg_reg;
        err_next         = err_reg;
        cnt_next         = cnt_reg;
        out_valid_next   = out_valid_reg;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        pixel_color_next = pixel_color_reg;
        last_pixel_next  = last_pixel_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (q_pop)
        begin
            busy_next   = 1'b1;
            x_next      = q_data.x0;
            y_next      = q_data.y0;
            x1_next     = q_data.x1;
            y1_next     = q_data.y1;
            dx_next     = q_data.dx;
            ady_next    = q_data.ady;
            sx_neg_next = q_data.sx_neg;
            sy_neg_next = q_data.sy_neg;
            err_next    = $signed({{EXT_W{1'b0}}, q_data.dx})
                        - $signed({{EXT_W{1'b0}}, q_data.ady});
            cnt_next    = '0;
        end
        else if (emit)
        begin
            out_valid_next   = 1'b1;
            pixel_x_next     = x_reg;
            pixel_y_next     = y_reg;
            pixel_color_next = draw_color;
            last_pixel_next  = done;
            if (done)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                err_next = err_reg + (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
                if (step_x)
                begin
                    x_next = sx_neg_reg ? x_reg - CW'(1) : x_reg + CW'(1);
                end
                if (step_y)
                begin
                    y_next = sy_neg_reg ? y_reg - CW'(1) : y_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg           <= x_next;
        y_reg           <= y_next;
        x1_reg          <= x1_next;
        y1_reg          <= y1_next;
        dx_reg          <= dx_next;
        ady_reg         <= ady_next;
        sx_neg_reg      <= sx_neg_next;
        sy_neg_reg      <= sy_neg_next;
        err_reg         <= err_next;
        cnt_reg         <= cnt_next;
        pixel_x_reg     <= pixel_x_next;
        pixel_y_reg     <= pixel_y_next;
        pixel_color_reg <= pixel_color_next;
        last_pixel_reg  <= last_pixel_next;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign pixel_color = pixel_color_reg;
    assign last_pixel  = last_pixel_reg;

    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        emit && done |=> !busy_reg && out_valid_reg && last_pixel_reg)
        else $error("final pixel did not end the line");

    a_count_advances: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !done |=> busy_reg && (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("pixel count did not advance");

    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && (cnt_reg == CNT_CAP) |-> done)
        else $error("line ran past the pixel cap");

endmodule

/* rtl/core/clamped_line_rasterizer.sv */
`timescale 1ns / 1ps

// Channel   Dir   Handshake              Payload
// -------   ---   ---------------------  --------------------------------------------
// in        in    in_valid / in_stall    start_x, start_y, end_x, end_y (s16)
// out       out   out_valid / out_stall  pixel_x, pixel_y (u6), pixel_color, last_pixel
// cfg       in    cfg_valid / cfg_ready  cfg_index (u2), cfg_data (u32)
//
// Each line leaves the queue and loads the stepper in clr_back, which then emits one pixel
// per cycle while out_stall is low; a new line is loaded only once the last one is done.
// Endpoints are clamped and set up in clr_front and wait in a two-entry queue.
// Reset (rst_n low, asynchronous) empties the queue, idles the stepper, drops any
// pending pixel and restores the canvas to 64 x 64 and the color to all ones.
// A held out_stall freezes output and stepper; requests enter until the queue fills.

module clamped_line_rasterizer #(
    parameter int MAX_DIM = clr_pkg::MAX_DIM_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [clr_pkg::IN_W-1:0]      start_x,
    input  logic signed [clr_pkg::IN_W-1:0]      start_y,
    input  logic signed [clr_pkg::IN_W-1:0]      end_x,
    input  logic signed [clr_pkg::IN_W-1:0]      end_y,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [clr_pkg::COORD_W-1:0]          pixel_x,
    output logic [clr_pkg::COORD_W-1:0]          pixel_y,
    output logic [clr_pkg::COLOR_W-1:0]          pixel_color,
    output logic                                 last_pixel,

    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [clr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [clr_pkg::COLOR_W-1:0]          cfg_data
);

    logic [clr_pkg::DIM_W-1:0]   canvas_width_reg, canvas_width_next;
    logic [clr_pkg::DIM_W-1:0]   canvas_height_reg, canvas_height_next;
    logic [clr_pkg::COLOR_W-1:0] draw_color_reg, draw_color_next;

    logic                 q_push, q_pop, q_full, q_empty;
    clr_pkg::line_setup_t q_wdata, q_rdata;

    // Register writes are always taken; an unknown index is dropped.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        canvas_width_next  = canvas_width_reg;
        canvas_height_next = canvas_height_reg;
        draw_color_next    = draw_color_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (clr_pkg::cfg_reg_t'(cfg_index))
                clr_pkg::CFG_WIDTH:  canvas_width_next  = cfg_data[clr_pkg::DIM_W-1:0];
                clr_pkg::CFG_HEIGHT: canvas_height_next = cfg_data[clr_pkg::DIM_W-1:0];
                clr_pkg::CFG_COLOR:  draw_color_next    = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            canvas_width_reg  <= clr_pkg::DIM_RESET;
            canvas_height_reg <= clr_pkg::DIM_RESET;
            draw_color_reg    <= clr_pkg::COLOR_RESET;
        end
        else
        begin
            canvas_width_reg  <= canvas_width_next;
            canvas_height_reg <= canvas_height_next;
            draw_color_reg    <= draw_color_next;
        end
    end

    // Front: clamp the endpoints and work out deltas and step directions.
    clr_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .canvas_width  (canvas_width_reg),
        .canvas_height (canvas_height_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_wdata)
    );

    // Queue: decouple the front from the stepper.
    clr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back: walk the line one pixel per cycle, while out_stall is low, into the output register.
    clr_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .draw_color  (draw_color_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule
